/* hdl/twpq_pkg.sv */
// Shared types and constants for the timed wakeup priority queue.
`timescale 1ns / 1ps

package twpq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TickW         = 64;
  localparam int unsigned TidW          = 8;
  localparam int unsigned PriW          = 6;
  localparam int unsigned SleepW        = 32;
  localparam int unsigned InDataW       = 48;
  localparam int unsigned OutDataW      = 8;

  // Input kind carried on the slave tuser bit
  localparam logic ModeSleep = 1'b0;
  localparam logic ModeTick  = 1'b1;

  // Result status carried on the master tuser bit
  localparam logic StatusWoken  = 1'b0;
  localparam logic StatusReject = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } twpq_state_e;

  // One queue slot
  typedef struct packed {
    logic             valid;
    logic [TickW-1:0] wake;
    logic [PriW-1:0]  pri;
    logic [TidW-1:0]  tid;
  } twpq_entry_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic             insert;
    logic             shift;
    logic [TickW-1:0] wake;
    logic [PriW-1:0]  pri;
    logic [TidW-1:0]  tid;
  } twpq_cmd_t;

  // Status of the chain head seen by the controller
  typedef struct packed {
    logic            full;
    logic            head_due;
    logic            next_due;
    logic [TidW-1:0] head_tid;
  } twpq_stat_t;

endpackage

/* hdl/twpq_cell.sv */
// One slot of the sorted sleeper chain: compare, insert, shift.
`timescale 1ns / 1ps

module twpq_cell
  import twpq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  twpq_cmd_t        cmd_i,
  input  logic [TickW-1:0] tick_i,
  input  twpq_entry_t      left_i,
  input  logic             left_ins_i,
  input  twpq_entry_t      right_i,
  output twpq_entry_t      entry_o,
  output logic             ins_o,
  output logic             due_o
);

  logic        valid_q, valid_d;
  twpq_entry_t ent_q;
  twpq_entry_t ent_d;
  logic        load;

  // New key goes at or before this slot
  always_comb begin
    ins_o = !valid_q ||
            ($signed(cmd_i.wake) < $signed(ent_q.wake)) ||
            ((cmd_i.wake == ent_q.wake) && (cmd_i.pri > ent_q.pri));
    due_o = valid_q && ($signed(ent_q.wake) <= $signed(tick_i));
  end

  // Pick the next slot content
  always_comb begin
    load    = 1'b0;
    ent_d   = ent_q;
    valid_d = valid_q;
    if (cmd_i.insert && ins_o) begin
      load = 1'b1;
      if (left_ins_i) begin
        ent_d   = left_i;
        valid_d = left_i.valid;
      end else begin
        ent_d.wake = cmd_i.wake;
        ent_d.pri  = cmd_i.pri;
        ent_d.tid  = cmd_i.tid;
        valid_d    = 1'b1;
      end
    end else if (cmd_i.shift) begin
      load    = 1'b1;
      ent_d   = right_i;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload carries no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= ent_d;
    end
  end

  always_comb begin
    entry_o       = ent_q;
    entry_o.valid = valid_q;
  end

endmodule

/* hdl/twpq_ctrl.sv */
// Tick counter, request sequencing and result register.
`timescale 1ns / 1ps

module twpq_ctrl
  import twpq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,
  input  logic               s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic               m_axis_tuser_o,
  output logic               m_axis_tlast_o,
  input  twpq_stat_t         stat_i,
  output twpq_cmd_t          cmd_o,
  output logic [TickW-1:0]   tick_o
);

  twpq_state_e state_q, state_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic out_valid_q, out_valid_d;
  logic [TidW-1:0] out_tid_q, out_tid_d;
  logic out_status_q, out_status_d;
  logic out_last_q, out_last_d;
  logic out_load, out_free, accept;
  logic [TidW-1:0]   req_tid;
  logic [PriW-1:0]   req_pri;
  logic [SleepW-1:0] req_sleep;

  assign req_tid   = s_axis_tdata_i[TidW-1:0];
  assign req_pri   = s_axis_tdata_i[TidW+PriW-1:TidW];
  assign req_sleep = s_axis_tdata_i[TidW+PriW+SleepW-1:TidW+PriW];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Sequence requests and the wakeup drain
  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    out_load     = 1'b0;
    out_tid_d    = out_tid_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    cmd_o.insert = 1'b0;
    cmd_o.shift  = 1'b0;
    cmd_o.wake   = tick_q + {{(TickW-SleepW){req_sleep[SleepW-1]}}, req_sleep};
    cmd_o.pri    = req_pri;
    cmd_o.tid    = req_tid;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == ModeTick) begin
            tick_d  = tick_q + 1'b1;
            state_d = ST_DRAIN;
          end else if (stat_i.full) begin
            out_load     = 1'b1;
            out_tid_d    = req_tid;
            out_status_d = StatusReject;
            out_last_d   = 1'b1;
          end else begin
            cmd_o.insert = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!stat_i.head_due) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_tid_d    = stat_i.head_tid;
          out_status_d = StatusWoken;
          out_last_d   = !stat_i.next_due;
          cmd_o.shift  = 1'b1;
          if (!stat_i.next_due) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register valid flag
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload until replaced
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_tid_q    <= out_tid_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;
  assign tick_o          = tick_q;

endmodule

/* hdl/timed_wakeup_priority_queue.sv */
// Top level: sorted chain of sleeper cells driven by the request controller.
//
//  channel  dir  tdata (low bit up)                          tuser   tlast
//  s_axis   in   thread_id[7:0] priority_req[13:8]           mode    -
//                sleep_ticks[45:14] zero[47:46]
//  m_axis   out  woken_id[7:0]                               status  last
//
// A sleep request is inserted at the edge that accepts it: every cell compares its key
// with the new one and the chain opens a gap in place. A tick bumps the tick count and
// enters ST_DRAIN, which takes no requests and ends once the chain head is not due;
// wakeups leave the chain head one a cycle while m_axis takes them, as the cells shift
// left. Reset clears the tick count and all slot valid bits. A stalled m_axis pauses
// the drain and blocks new requests until the result is taken.
`timescale 1ns / 1ps

module timed_wakeup_priority_queue
  import twpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // thread_id, priority_req, sleep_ticks
  input  logic                s_axis_tuser_i,   // mode
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // woken_id
  output logic                m_axis_tuser_o,   // status
  output logic                m_axis_tlast_o    // last
);

  twpq_cmd_t        cmd;
  twpq_stat_t       stat;
  logic [TickW-1:0] tick;
  twpq_entry_t      entries [QUEUE_DEPTH+1];
  logic             ins [QUEUE_DEPTH+1];
  logic             due [QUEUE_DEPTH];

  twpq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .stat_i          (stat),
    .cmd_o           (cmd),
    .tick_o          (tick)
  );

  // Chain ends: nothing inserts before the head, empty slot past the tail
  assign ins[0]                = 1'b0;
  assign entries[QUEUE_DEPTH]  = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    twpq_entry_t left;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = entries[i-1];
    end

    twpq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .tick_i     (tick),
      .left_i     (left),
      .left_ins_i (ins[i]),
      .right_i    (entries[i+1]),
      .entry_o    (entries[i]),
      .ins_o      (ins[i+1]),
      .due_o      (due[i])
    );
  end

  // Head status for the controller
  assign stat.full     = entries[QUEUE_DEPTH-1].valid;
  assign stat.head_due = due[0];
  assign stat.next_due = due[1];
  assign stat.head_tid = entries[0].tid;

endmodule

/* hdl/twpq_checker.sv */
// Port-level checks for the timed wakeup priority queue, bound to the top.
`timescale 1ns / 1ps

module twpq_checker
  import twpq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [InDataW-1:0]  s_axis_tdata_i,
  input logic                s_axis_tuser_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tuser_o,
  input logic                m_axis_tlast_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // A rejection is always a single, final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == StatusReject) |-> m_axis_tlast_o)
    else $error("rejection without last");

  // No request is taken while a result waits on a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("request taken over a stalled result");

  // A tick always starts a drain pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ModeTick) |=>
      !s_axis_tready_o)
    else $error("tick did not start a drain");

endmodule

bind timed_wakeup_priority_queue twpq_checker u_twpq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* tb/tb_timed_wakeup_priority_queue.sv */
// Self-checking testbench for the timed wakeup priority queue.
`timescale 1ns / 1ps

module tb_timed_wakeup_priority_queue;
  import twpq_pkg::*;

  localparam int QDEPTH      = QueueDepthDef;
  localparam int STALL_LIMIT = 2000;
  localparam int N_RANDOM    = 350;
  localparam int N_CALM      = 60;
  localparam int DRAIN_WAIT  = 2 * QDEPTH + 8;

  // One sleeper as the model of the chain keeps it
  typedef struct packed {
    logic [TickW-1:0] wake;
    logic [PriW-1:0]  pri;
    logic [TidW-1:0]  tid;
  } sleeper_t;

  // One wakeup or rejection as it should leave m_axis
  typedef struct packed {
    logic            status;
    logic [TidW-1:0] id;
    logic            last;
  } wakeup_t;

  // Outcome typed into a directed row: result count and, for one result, its fields
  typedef struct {
    logic            on;
    int              n;
    logic            status;
    logic [TidW-1:0] id;
  } pinned_t;

  typedef struct {
    logic              mode;
    logic [TidW-1:0]   tid;
    logic [PriW-1:0]   pri;
    logic [SleepW-1:0] ticks;
    int                rep;
    pinned_t           pin;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                s_user = ModeSleep;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_user;
  logic                m_last;

  // Model of the block and the wakeups it owes
  logic [TickW-1:0] model_tick = '0;
  sleeper_t         sleepers[$];
  wakeup_t          due_wakeups[$];
  pinned_t          pinned_q[$];

  int  mismatches = 0;
  int  n_sleep = 0, n_tick = 0, n_woken = 0, n_reject = 0, most_per_item = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  timed_wakeup_priority_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // thread_id, priority_req, sleep_ticks
    .s_axis_tuser_i  (s_user),   // mode
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // woken_id
    .m_axis_tuser_o  (m_user),   // status
    .m_axis_tlast_o  (m_last)    // last
  );

  always #10 clk_i = ~clk_i;

  // Advance the model by one request and queue the wakeups it causes
  function automatic int step_sleepers(input logic mode, input logic [TidW-1:0] tid,
                                       input logic [PriW-1:0] pri,
                                       input logic [SleepW-1:0] ticks);
    logic [TickW-1:0] wake;
    sleeper_t         s;
    int               pos;
    int               i;
    int               n;
    n = 0;
    if (mode == ModeSleep) begin
      if (sleepers.size() >= QDEPTH) begin
        due_wakeups.push_back('{StatusReject, tid, 1'b1});
        return 1;
      end
      wake = model_tick + {{(TickW - SleepW){ticks[SleepW-1]}}, ticks};
      pos  = sleepers.size();
      for (i = 0; i < sleepers.size(); i++) begin
        if ($signed(wake) < $signed(sleepers[i].wake) ||
            (wake == sleepers[i].wake && pri > sleepers[i].pri)) begin
          pos = i;
          break;
        end
      end
      s = '{wake, pri, tid};
      sleepers.insert(pos, s);
      return 0;
    end
    model_tick += 1;
    while (sleepers.size() > 0 && $signed(sleepers[0].wake) <= $signed(model_tick)) begin
      due_wakeups.push_back('{StatusWoken, sleepers[0].tid, 1'b0});
      void'(sleepers.pop_front());
      n++;
    end
    if (n > 0) due_wakeups[due_wakeups.size() - 1].last = 1'b1;
    return n;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin : scoreboard
    logic [TidW-1:0]   tid;
    logic [PriW-1:0]   pri;
    logic [SleepW-1:0] ticks;
    pinned_t           pin;
    wakeup_t           got;
    wakeup_t           want;
    int                n;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        tid   = s_data[TidW-1:0];
        pri   = s_data[TidW+PriW-1:TidW];
        ticks = s_data[TidW+PriW+SleepW-1:TidW+PriW];
        n     = step_sleepers(s_user, tid, pri, ticks);
        pin   = pinned_q.pop_front();
        if (s_user == ModeTick) n_tick++;
        else n_sleep++;
        if (n > most_per_item) most_per_item = n;
        if (pin.on) begin
          if (n != pin.n)
            flag_mismatch($sformatf("directed request: %0d results predicted, table says %0d",
                                    n, pin.n));
          else if (n == 1 && (due_wakeups[due_wakeups.size() - 1].status != pin.status ||
                              due_wakeups[due_wakeups.size() - 1].id != pin.id))
            flag_mismatch($sformatf("directed request: predicted %p, table says %0d/%02h",
                                    due_wakeups[due_wakeups.size() - 1], pin.status, pin.id));
        end
      end
      if (m_valid && m_ready) begin
        got = '{m_user, m_data, m_last};
        if (got.status == StatusReject) n_reject++;
        else n_woken++;
        if (due_wakeups.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status=%0d id=%02h last=%0d",
                                  got.status, got.id, got.last));
        end else begin
          want = due_wakeups.pop_front();
          if (got.status != want.status)
            flag_mismatch($sformatf("status: expected %0d, got %0d (id %02h)",
                                    want.status, got.status, want.id));
          if (got.id != want.id)
            flag_mismatch($sformatf("woken_id: expected %02h, got %02h", want.id, got.id));
          if (got.last != want.last)
            flag_mismatch($sformatf("last: expected %0d, got %0d (id %02h)",
                                    want.last, got.last, want.id));
        end
      end
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_ready <= 1'b1;
    end else if (stall_left > 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_ready    <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      m_ready <= 1'b1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one request and hold it until taken, then maybe idle a while
  task automatic send_request(input logic mode, input logic [TidW-1:0] tid,
                              input logic [PriW-1:0] pri, input logic [SleepW-1:0] ticks,
                              input pinned_t pin);
    bit taken;
    pinned_q.push_back(pin);
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= {{(InDataW - SleepW - PriW - TidW){1'b0}}, ticks, pri, tid};
    do begin
      @(negedge clk_i);
      taken = s_ready;
      @(posedge clk_i);
    end while (!taken);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Hold off until the block owes nothing
  task automatic wait_all_woken();
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (due_wakeups.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Directed rows: reset state, field extremes, ordering ties, full queue, longest drain
  stim_row_t directed[15] = '{
    '{ModeTick,  8'h00, 6'd0,  32'h0000_0000, 1,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeSleep, 8'h00, 6'd0,  32'h0000_0000, 1,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeTick,  8'h00, 6'd0,  32'h0000_0000, 1,  '{1'b1, 1, StatusWoken,  8'h00}},
    '{ModeSleep, 8'hFF, 6'd63, 32'hFFFF_FFFF, 1,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeSleep, 8'hA5, 6'd0,  32'h8000_0000, 1,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeSleep, 8'h11, 6'd5,  32'h0000_0001, 1,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeSleep, 8'h22, 6'd9,  32'h0000_0001, 1,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeSleep, 8'h33, 6'd5,  32'h0000_0001, 1,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeTick,  8'hFF, 6'd63, 32'hFFFF_FFFF, 1,  '{1'b0, 0, StatusWoken,  8'h00}},
    '{ModeSleep, 8'h40, 6'd0,  32'h0000_0003, 16, '{1'b0, 0, StatusWoken,  8'h00}},
    '{ModeSleep, 8'hC3, 6'd63, 32'h0000_0000, 1,  '{1'b1, 1, StatusReject, 8'hC3}},
    '{ModeTick,  8'h00, 6'd0,  32'h0000_0000, 2,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeTick,  8'h00, 6'd0,  32'h0000_0000, 1,  '{1'b0, 0, StatusWoken,  8'h00}},
    '{ModeSleep, 8'h5A, 6'd63, 32'h7FFF_FFFF, 1,  '{1'b1, 0, StatusWoken,  8'h00}},
    '{ModeTick,  8'h00, 6'd0,  32'h0000_0000, 1,  '{1'b1, 0, StatusWoken,  8'h00}}
  };

  initial begin : stimulus
    pinned_t           free_pin;
    logic              mode;
    logic [TidW-1:0]   tid;
    logic [PriW-1:0]   pri;
    logic [SleepW-1:0] ticks;
    int                tick_pct;
    int                r;
    free_pin = '{1'b0, 0, StatusWoken, '0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; repeated sleeps get rising ids and cycling priorities
    foreach (directed[k]) begin
      for (int i = 0; i < directed[k].rep; i++) begin
        send_request(directed[k].mode, directed[k].tid + TidW'(i),
                     directed[k].pri ^ PriW'((i % 4) * 21), directed[k].ticks,
                     directed[k].pin);
      end
    end
    wait_all_woken();

    // Random traffic in chunks that lean toward sleeps or toward ticks
    tick_pct = 50;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) begin
        r        = $urandom_range(0, 2);
        tick_pct = (r == 0) ? 20 : (r == 1) ? 50 : 75;
        idle_on  = ($urandom_range(0, 2) != 0);
      end
      if (i >= N_RANDOM - N_CALM) idle_on = 1'b0;
      mode = ($urandom_range(0, 99) < tick_pct) ? ModeTick : ModeSleep;
      tid  = TidW'($urandom);
      pri  = ($urandom_range(0, 2) == 0) ? PriW'($urandom_range(0, 3) * 21) : PriW'($urandom);
      r    = $urandom_range(0, 9);
      if (r < 7)      ticks = SleepW'($urandom_range(0, 12)) - SleepW'(3);
      else if (r < 9) ticks = {1'b1, 31'($urandom)};
      else            ticks = SleepW'($urandom_range(0, 40));
      send_request(mode, tid, pri, ticks, free_pin);
    end

    wait_all_woken();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d sleep requests and %0d ticks after reset, with both sides stalling",
             n_sleep, n_tick);
    $display("Saw %0d wakeups and %0d full-queue rejections, up to %0d results from one request",
             n_woken, n_reject, most_per_item);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
